// File: sv/tkcs_pkg.sv
// Package for the top-k candidate selector: entry and result types, codes,
// reset values and read-tree sizing shared by the cell, reader and top level.
// Depends on nothing.
package tkcs_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 64;
  localparam int GROUP_SIZE = 8;
  localparam int GROUP_BITS = 3;

  localparam logic [6:0]  CAPACITY_RESET = 7'd64;
  localparam logic [15:0] MARGIN_RESET   = 16'd17;

  // configuration register indexes
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_MARGIN   = 1'b1;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PRUNE = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_POPPED   = 3'd3,
    ST_NONE     = 3'd4,
    ST_PRUNED   = 3'd5,
    ST_CLEARED  = 3'd6
  } status_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic [31:0]        block;
    logic [15:0]        offset;
  } entry_t;

  // per-cell control from the top level
  typedef struct packed {
    logic wr;     // cell takes part in this insert/replace
    logic last;   // cell is the top slot of the shifted range
  } cell_ctrl_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] score;
    logic [31:0]        block;
    logic [15:0]        offset;
    logic               prune;
    logic [6:0]         held;
  } result_t;

  // address width of the two-level read tree for n entries
  function automatic int tkcs_addr_bits(int n);
    int ng;
    ng = (n + GROUP_SIZE - 1) / GROUP_SIZE;
    return GROUP_BITS + ((ng > 1) ? $clog2(ng) : 1);
  endfunction

endpackage

// File: sv/tkcs_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the incoming
// candidate and shifts up from its lower neighbor on insert. Uses tkcs_pkg.
module tkcs_cell import tkcs_pkg::*; (
  input  logic       clk,
  input  entry_t     cand,
  input  entry_t     left_entry,
  input  logic       left_after,
  input  cell_ctrl_t ctrl,
  output entry_t     entry,
  output logic       after
);

  // this entry orders strictly after the candidate
  always_comb begin
    if (entry.score != cand.score) begin
      after = entry.score > cand.score;
    end else if (entry.block != cand.block) begin
      after = entry.block > cand.block;
    end else begin
      after = entry.offset > cand.offset;
    end
  end

  // shift from below when the lower neighbor is greater, else take candidate if this entry is greater or last
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      if (left_after) begin
        entry <= left_entry;
      end else if (after || ctrl.last) begin
        entry <= cand;
      end
    end
  end

endmodule

// File: sv/tkcs_reader.sv
// Two-level registered read tree over the chain's entries: groups of eight
// are narrowed in the first stage, the group is picked in the second.
// Uses tkcs_pkg.
module tkcs_reader import tkcs_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic                                   clk,
  input  entry_t                                 entries [MAX_ENTRIES],
  input  logic [tkcs_addr_bits(MAX_ENTRIES)-1:0] addr,
  output entry_t                                 rd_data
);

  localparam int NUM_GROUPS = (MAX_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int RAW = tkcs_addr_bits(MAX_ENTRIES);
  localparam int GW = RAW - GROUP_BITS;

  entry_t          grp_q [NUM_GROUPS];
  logic [GW-1:0]   hi_q;

  // stage one: pick within each group
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    entry_t cand [GROUP_SIZE];
    for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_tap
      if (g * GROUP_SIZE + k < MAX_ENTRIES) begin : g_real
        assign cand[k] = entries[g * GROUP_SIZE + k];
      end else begin : g_pad
        assign cand[k] = '0;
      end
    end
    always_ff @(posedge clk) begin
      grp_q[g] <= cand[addr[GROUP_BITS-1:0]];
    end
  end

  // stage two: pick the group
  always_ff @(posedge clk) begin
    hi_q    <= addr[RAW-1:GROUP_BITS];
    rd_data <= grp_q[hi_q];
  end

endmodule

// File: sv/top_k_candidate_selector.sv
// Top level of the top-k candidate selector: sorted chain of cells, read tree,
// control sequencer and output skid. Uses tkcs_pkg, tkcs_cell, tkcs_reader.
//
// Keeps the best (smallest by score, then block, then offset) candidates, up
// to the configured capacity, in a chain of cells kept in ascending order. A
// push or clear is done at the edge that accepts it; on a push every cell
// compares itself with the candidate and the chain shifts by one slot unless
// the push is rejected. A pop or prune query is answered once its entry is
// fetched through a two-level registered read tree (groups of eight, then the
// group). One transaction is in progress at a time; a finished result waits
// in the output register and one more in a skid stage behind it; the input
// is stalled only while a pop/prune is in progress or the skid is full.
// Entries are not cleared on reset; only slots below the held count are used.
module top_k_candidate_selector import tkcs_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         action,
  input  logic signed [31:0] score,
  input  logic [31:0]        cand_block,
  input  logic [15:0]        cand_offset,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         status,
  output logic signed [31:0] out_score,
  output logic [31:0]        out_block,
  output logic [15:0]        out_offset,
  output logic               prune,
  output logic [6:0]         held_count,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int W   = (CW > 7) ? CW : 7;
  localparam int RAW = tkcs_addr_bits(MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_GATHER = 4'b0010,
    S_PICK   = 4'b0100,
    S_ANSWER = 4'b1000
  } state_t;

  state_t             state;
  logic [CW-1:0]      held;
  logic [CW-1:0]      held_next;
  logic [CW-1:0]      pop_position;
  logic [6:0]         capacity;
  logic [15:0]        prune_margin;
  logic [RAW-1:0]     rd_addr;
  logic               pend_pop;
  logic               pend_hit;
  logic signed [31:0] pend_score;

  entry_t             cand;
  entry_t             cell_entry [MAX_ENTRIES];
  logic               cell_after [MAX_ENTRIES];
  cell_ctrl_t         cell_ctrl  [MAX_ENTRIES];
  entry_t             rd_data;

  logic               accept;
  action_t            act;
  logic [W-1:0]       cap_eff;
  logic               room;
  logic [CW-1:0]      held_m1;
  logic               worst_after;
  logic               shift_en;
  logic [CW-1:0]      last;

  result_t            res_new;
  logic               res_new_valid;
  result_t            out_q;
  result_t            skid_q;
  logic               skid_v;
  logic               out_take;
  logic signed [33:0] limit;
  logic signed [33:0] probe;

  assign cfg_ready = 1'b1;
  assign item_stall = (state != S_IDLE) || skid_v;
  assign accept = item_valid && !item_stall;
  assign act = action_t'(action);
  assign cand = '{score: score, block: cand_block, offset: cand_offset};

  // effective capacity: zero acts as one, above the chain length as the length
  always_comb begin
    if (capacity == 7'd0) begin
      cap_eff = W'(1);
    end else if (W'(capacity) > W'(MAX_ENTRIES)) begin
      cap_eff = W'(MAX_ENTRIES);
    end else begin
      cap_eff = W'(capacity);
    end
  end

  assign room = W'(held) < cap_eff;
  assign held_m1 = held - CW'(1);
  assign worst_after = (held != '0) && cell_after[held_m1[AW-1:0]];
  assign shift_en = accept && (act == ACT_PUSH) && (room || worst_after);
  assign last = room ? held : held_m1;

  // cell controls: slots up to the top of the range take part
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_ctrl[i].wr   = shift_en && (CW'(i) <= last);
      cell_ctrl[i].last = (CW'(i) == last);
    end
  end

  // sorted chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t left_entry;
    logic   left_after;
    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_after = 1'b0;
    end else begin : g_rest
      assign left_entry = cell_entry[i-1];
      assign left_after = cell_after[i-1];
    end
    tkcs_cell u_cell (
      .clk        (clk),
      .cand       (cand),
      .left_entry (left_entry),
      .left_after (left_after),
      .ctrl       (cell_ctrl[i]),
      .entry      (cell_entry[i]),
      .after      (cell_after[i])
    );
  end

  tkcs_reader #(.MAX_ENTRIES(MAX_ENTRIES)) u_reader (
    .clk     (clk),
    .entries (cell_entry),
    .addr    (rd_addr),
    .rd_data (rd_data)
  );

  // held count after a push or clear
  always_comb begin
    held_next = held;
    if (accept && act == ACT_CLEAR) begin
      held_next = '0;
    end else if (shift_en && room) begin
      held_next = held + CW'(1);
    end
  end

  // prune test against the worst entry plus margin
  assign limit = {{2{rd_data.score[31]}}, rd_data.score} + $signed({18'd0, prune_margin});
  assign probe = {{2{pend_score[31]}}, pend_score};

  // result formed at accept (push, clear) or at the end of a read
  always_comb begin
    res_new = '0;
    res_new_valid = 1'b0;
    res_new.held = 7'(held_next);
    if (accept && act == ACT_PUSH) begin
      res_new_valid = 1'b1;
      if (!shift_en) begin
        res_new.status = ST_REJECTED;
      end else if (room) begin
        res_new.status = ST_INSERTED;
      end else begin
        res_new.status = ST_REPLACED;
      end
    end else if (accept && act == ACT_CLEAR) begin
      res_new_valid = 1'b1;
      res_new.status = ST_CLEARED;
    end else if (state == S_ANSWER) begin
      res_new_valid = 1'b1;
      if (pend_pop) begin
        if (pend_hit) begin
          res_new.status = ST_POPPED;
          res_new.score  = rd_data.score;
          res_new.block  = rd_data.block;
          res_new.offset = rd_data.offset;
        end else begin
          res_new.status = ST_NONE;
        end
      end else begin
        res_new.status = ST_PRUNED;
        res_new.prune  = pend_hit && (probe > limit);
      end
    end
  end

  // control state, configuration and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      held         <= '0;
      pop_position <= '0;
      capacity     <= CAPACITY_RESET;
      prune_margin <= MARGIN_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAPACITY: capacity <= cfg_data[6:0];
          CFG_MARGIN:   prune_margin <= cfg_data;
          default:      ;
        endcase
      end
      held <= held_next;
      if (shift_en || (accept && act == ACT_CLEAR)) begin
        pop_position <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept && act == ACT_POP) begin
            state <= S_GATHER;
            if (pop_position < held) begin
              pop_position <= pop_position + CW'(1);
            end
          end else if (accept && act == ACT_PRUNE) begin
            state <= S_GATHER;
          end
        end
        S_GATHER: state <= S_PICK;
        S_PICK:   state <= S_ANSWER;
        S_ANSWER: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // pending pop/prune details
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_pop   <= (act == ACT_POP);
      pend_score <= score;
      if (act == ACT_POP) begin
        pend_hit <= pop_position < held;
        rd_addr  <= RAW'(pop_position);
      end else begin
        pend_hit <= (W'(held) >= cap_eff) && (held != '0);
        rd_addr  <= RAW'(held_m1);
      end
    end
  end

  // output register with skid stage behind it
  assign out_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (!result_valid || out_take) begin
      if (skid_v) begin
        result_valid <= 1'b1;
        skid_v       <= res_new_valid;
      end else begin
        result_valid <= res_new_valid;
      end
    end else if (res_new_valid) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || out_take) begin
      if (skid_v) begin
        out_q  <= skid_q;
        skid_q <= res_new;
      end else begin
        out_q <= res_new;
      end
    end else if (res_new_valid) begin
      skid_q <= res_new;
    end
  end

  assign status     = out_q.status;
  assign out_score  = out_q.score;
  assign out_block  = out_q.block;
  assign out_offset = out_q.offset;
  assign prune      = out_q.prune;
  assign held_count = out_q.held;

  // skid holds a result only behind a valid output register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> result_valid)
    else $error("skid full while output register empty");

  // held count never exceeds the chain length
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    W'(held) <= W'(MAX_ENTRIES))
    else $error("held count beyond chain length");

  // pop position never runs past the held entries
  a_pop_bound: assert property (@(posedge clk) disable iff (rst)
    pop_position <= held)
    else $error("pop position beyond held count");

  // a pop or prune read always ends with a result
  a_answer: assert property (@(posedge clk) disable iff (rst)
    (state == S_ANSWER) |-> res_new_valid)
    else $error("read finished without a result");

endmodule
